@@ rtl/core/ola_pkg.sv @@
// Shared types and codes for the ordered list block.
// Depends on nothing; used by ola_mem, ola_ctrl and ordered_list_append_delete.
package ola_pkg;

	localparam int unsigned DATA_W = 32;

	// request modes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_LIST   = 2'd2;

	// result status codes
	localparam logic [2:0] STAT_INSERTED  = 3'd0;
	localparam logic [2:0] STAT_DELETED   = 3'd1;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
	localparam logic [2:0] STAT_EMPTY     = 3'd3;
	localparam logic [2:0] STAT_FULL      = 3'd4;
	localparam logic [2:0] STAT_LISTED    = 3'd5;

	typedef struct packed {
		logic [1:0]               mode;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]               status;
		logic signed [DATA_W-1:0] item;
		logic                     last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SEARCH,
		ST_SHIFT,
		ST_LIST,
		ST_EMIT
	} state_t;

endpackage

@@ rtl/core/ola_mem.sv @@
// Entry store: one write port, one read port, registered read data.
// Depends on ola_pkg for the data width.
module ola_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic signed [ola_pkg::DATA_W-1:0] wdata,
	input  logic                              re,
	input  logic [AW-1:0]                     raddr,
	output logic signed [ola_pkg::DATA_W-1:0] rdata
);

	logic signed [ola_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/ola_ctrl.sv @@
// Sequencer for insert, delete-with-shift and list over the entry store,
// with the entry counter and the result register. Depends on ola_pkg.
module ola_ctrl #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned AW       = 4,
	parameter int unsigned CW       = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  ola_pkg::req_t                     req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output ola_pkg::rsp_t                     rsp,
	output logic [CW-1:0]                     count,
	output logic                              mem_we,
	output logic [AW-1:0]                     mem_waddr,
	output logic signed [ola_pkg::DATA_W-1:0] mem_wdata,
	output logic                              mem_re,
	output logic [AW-1:0]                     mem_raddr,
	input  logic signed [ola_pkg::DATA_W-1:0] mem_rdata
);

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	ola_pkg::state_t state_q, state_d;
	ola_pkg::req_t   req_q;
	ola_pkg::rsp_t   out_q, out_d;
	logic            out_valid_q;
	logic            load_out;
	logic            can_emit;
	logic [CW-1:0]   idx_q, idx_d, idx_nxt;
	logic [CW:0]     idx_nxt2;
	logic [CW-1:0]   count_q, count_d;
	logic [2:0]      stat_q, stat_d;

	assign can_emit = !out_valid_q || rsp_ready;
	assign idx_nxt  = idx_q + 1'b1;
	assign idx_nxt2 = {1'b0, idx_q} + (CW+1)'(2);

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ola_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		stat_q <= stat_d;
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		count_d   = count_q;
		stat_d    = stat_q;
		load_out  = 1'b0;
		out_d     = '{status: stat_q, item: req_q.value, last: 1'b1};
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = idx_nxt[AW-1:0];
		req_ready = 1'b0;
		case (state_q)
			ola_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ola_pkg::ST_START;
				end
			end
			ola_pkg::ST_START: begin
				idx_d = '0;
				case (req_q.mode)
					ola_pkg::MODE_INSERT: begin
						if (count_q == CAP_C) begin
							stat_d = ola_pkg::STAT_FULL;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = count_q[AW-1:0];
							mem_wdata = req_q.value;
							count_d   = count_q + 1'b1;
							stat_d    = ola_pkg::STAT_INSERTED;
						end
						state_d = ola_pkg::ST_EMIT;
					end
					ola_pkg::MODE_DELETE, ola_pkg::MODE_LIST: begin
						if (count_q == '0) begin
							stat_d  = ola_pkg::STAT_EMPTY;
							state_d = ola_pkg::ST_EMIT;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = '0;
							state_d   = (req_q.mode == ola_pkg::MODE_LIST) ?
								ola_pkg::ST_LIST : ola_pkg::ST_SEARCH;
						end
					end
					default: begin
						state_d = ola_pkg::ST_IDLE;
					end
				endcase
			end
			ola_pkg::ST_SEARCH: begin
				// read data is entry idx_q; the next entry is fetched alongside
				if (mem_rdata == req_q.value) begin
					state_d = ola_pkg::ST_SHIFT;
					mem_re  = (idx_nxt < count_q);
				end else if (idx_nxt == count_q) begin
					stat_d  = ola_pkg::STAT_NOT_FOUND;
					state_d = ola_pkg::ST_EMIT;
				end else begin
					mem_re = 1'b1;
					idx_d  = idx_nxt;
				end
			end
			ola_pkg::ST_SHIFT: begin
				// read data is entry idx_q+1, moved down into idx_q
				if (idx_nxt < count_q) begin
					mem_we    = 1'b1;
					mem_waddr = idx_q[AW-1:0];
					mem_wdata = mem_rdata;
					idx_d     = idx_nxt;
					mem_re    = (idx_nxt2 < {1'b0, count_q});
					mem_raddr = idx_nxt2[AW-1:0];
				end else begin
					count_d = count_q - 1'b1;
					stat_d  = ola_pkg::STAT_DELETED;
					state_d = ola_pkg::ST_EMIT;
				end
			end
			ola_pkg::ST_LIST: begin
				if (can_emit) begin
					load_out = 1'b1;
					out_d    = '{status: ola_pkg::STAT_LISTED, item: mem_rdata,
						last: (idx_nxt == count_q)};
					if (idx_nxt == count_q) begin
						state_d = ola_pkg::ST_IDLE;
					end else begin
						mem_re = 1'b1;
						idx_d  = idx_nxt;
					end
				end
			end
			ola_pkg::ST_EMIT: begin
				if (can_emit) begin
					load_out = 1'b1;
					state_d  = ola_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ola_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/ordered_list_append_delete.sv @@
// Ordered list of up to CAPACITY signed values held in a single-port-pair RAM.
// Insert, full and empty: the request passes START and EMIT, and the response is registered.
// Delete: the response follows search and shift, which together visit each entry once.
// List: entries follow in order, one a cycle while responses are taken.
// One request at a time; a waiting response holds the sequencer until it is taken.
// Reset clears the entry count and controller; RAM contents need no clearing.
module ordered_list_append_delete #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ola_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ola_pkg::rsp_t rsp
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic                              mem_we;
	logic [AW-1:0]                     mem_waddr;
	logic signed [ola_pkg::DATA_W-1:0] mem_wdata;
	logic                              mem_re;
	logic [AW-1:0]                     mem_raddr;
	logic signed [ola_pkg::DATA_W-1:0] mem_rdata;
	logic [CW-1:0]                     count;

	ola_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.count     (count),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ola_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count != $past(count)) |-> (count == $past(count) + 1'b1 ||
			count + 1'b1 == $past(count)))
		else $error("entry count moved by more than one");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("new transaction taken while one is in progress");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("waiting response dropped or changed");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ({1'b0, mem_waddr} < (AW+1)'(CAPACITY)))
		else $error("RAM write beyond capacity");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for ordered_list_append_delete: directed and random requests.
// Depends on ola_pkg and the ordered_list_append_delete RTL; reads and writes no files.
// A scoreboard class mirrors the list, and every response is checked in order.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ola_pkg::*;

	localparam int unsigned CAPACITY    = 16;
	localparam logic [1:0]  MODE_UNUSED = 2'd3;
	localparam int          N_RANDOM    = 440;
	localparam int          MAX_REPORTS = 10;

	// Mirrors the list contents and queues the responses that each request should produce.
	class list_scoreboard;
		logic signed [DATA_W-1:0] entries[$];
		rsp_t                     expected_rsps[$];
		int                       errors;
		int                       checked;
		int                       peak;
		int                       mode_count[4];
		int                       status_count[8];

		function new();
			errors  = 0;
			checked = 0;
			peak    = 0;
			foreach (mode_count[i]) mode_count[i] = 0;
			foreach (status_count[i]) status_count[i] = 0;
		endfunction

		function void push_rsp(logic [2:0] status, logic signed [DATA_W-1:0] item, logic last);
			rsp_t r;
			r.status = status;
			r.item   = item;
			r.last   = last;
			expected_rsps.push_back(r);
			status_count[status]++;
		endfunction

		// Called for every accepted request transaction.
		function void note_request(req_t r);
			int hit;
			hit = -1;
			mode_count[r.mode]++;
			case (r.mode)
				MODE_INSERT: begin
					if (entries.size() >= CAPACITY) begin
						push_rsp(STAT_FULL, r.value, 1'b1);
					end else begin
						entries.push_back(r.value);
						push_rsp(STAT_INSERTED, r.value, 1'b1);
					end
				end
				MODE_DELETE: begin
					if (entries.size() == 0) begin
						push_rsp(STAT_EMPTY, r.value, 1'b1);
					end else begin
						foreach (entries[i]) begin
							if (hit < 0 && entries[i] == r.value) hit = i;
						end
						if (hit < 0) begin
							push_rsp(STAT_NOT_FOUND, r.value, 1'b1);
						end else begin
							entries.delete(hit);
							push_rsp(STAT_DELETED, r.value, 1'b1);
						end
					end
				end
				MODE_LIST: begin
					if (entries.size() == 0) begin
						push_rsp(STAT_EMPTY, r.value, 1'b1);
					end else begin
						foreach (entries[i])
							push_rsp(STAT_LISTED, entries[i], i == entries.size() - 1);
					end
				end
				default: begin
					// unused mode: no response, list untouched
				end
			endcase
			if (entries.size() > peak) peak = entries.size();
		endfunction

		// Called for every accepted response transaction.
		function void check_response(rsp_t got);
			rsp_t want;
			checked++;
			if (expected_rsps.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected response: status %0d item %h last %0d",
						got.status, got.item, got.last);
				return;
			end
			want = expected_rsps.pop_front();
			if (got.status !== want.status || got.item !== want.item || got.last !== want.last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("mismatch on response %0d: expected %0d/%h/%0d, got %0d/%h/%0d",
						checked, want.status, want.item, want.last,
						got.status, got.item, got.last);
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_ready;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_ready;
	rsp_t  rsp;

	list_scoreboard           sb;
	int                       sent;
	logic signed [DATA_W-1:0] pool[12];

	ordered_list_append_delete #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d responses outstanding", sb.expected_rsps.size());
		$display("testbench: FAIL");
		$finish;
	end

	// Both handshakes are sampled in one place, so noting and checking keep a fixed order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) sb.note_request(req);
			if (rsp_valid && rsp_ready) sb.check_response(rsp);
		end
	end

	// Response side: random back-pressure, one long hold-off, and a stretch always ready.
	initial begin
		int  rsp_seen;
		int  hold_left;
		bit  held;
		rsp_seen  = 0;
		hold_left = 0;
		held      = 1'b0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready) rsp_seen++;
			if (!held && rsp_seen >= 80) begin
				held      = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (rsp_seen >= 400 && rsp_seen < 700) begin
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= ($urandom_range(99) >= 25);
			end
		end
	end

	// Offers one request and returns at the edge where it is accepted.
	task automatic send_req(logic [1:0] mode, logic signed [DATA_W-1:0] value);
		// no gaps for a stretch in the middle of the random part
		if (sent < 200 || sent >= 290) begin
			while ($urandom_range(99) < 25) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid  <= 1'b1;
		req.mode   <= mode;
		req.value  <= value;
		do @(posedge clk); while (!req_ready);
		sent++;
	endtask

	task automatic send_random(bit filling);
		int                       pick;
		logic [1:0]               mode;
		logic signed [DATA_W-1:0] value;
		pick = $urandom_range(99);
		if (filling)
			mode = pick < 55 ? MODE_INSERT : pick < 80 ? MODE_DELETE
				: pick < 96 ? MODE_LIST : MODE_UNUSED;
		else
			mode = pick < 25 ? MODE_INSERT : pick < 75 ? MODE_DELETE
				: pick < 95 ? MODE_LIST : MODE_UNUSED;
		// mostly pooled values so deletes find matches and duplicates build up
		if ($urandom_range(3) == 0) value = $urandom;
		else value = pool[$urandom_range(11)];
		send_req(mode, value);
	endtask

	initial begin
		logic signed [DATA_W-1:0] tail_val;
		sb        = new();
		sent      = 0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		pool[0]   = 32'sh8000_0000;
		pool[1]   = 32'sh7fff_ffff;
		pool[2]   = '0;
		pool[3]   = -1;
		for (int i = 4; i < 12; i++)
			pool[i] = (i < 8) ? $signed($urandom_range(9)) - 5 : $signed($urandom);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, unused mode, fill with extremes and a duplicate, overflow
		send_req(MODE_LIST, 32'sh5a5a_5a5a);
		send_req(MODE_DELETE, 32'sh8000_0000);
		send_req(MODE_UNUSED, 32'sh7fff_ffff);
		send_req(MODE_INSERT, 32'sh8000_0000);
		send_req(MODE_INSERT, 32'sh7fff_ffff);
		send_req(MODE_INSERT, 32'sh0000_0000);
		send_req(MODE_INSERT, -32'sd1);
		send_req(MODE_INSERT, 32'sd1);
		send_req(MODE_INSERT, -32'sd1);
		send_req(MODE_INSERT, 32'sha5a5_a5a5);
		send_req(MODE_INSERT, 32'sh5a5a_5a5a);
		for (int i = 0; i < 8; i++) begin
			tail_val = $urandom;
			send_req(MODE_INSERT, tail_val);
		end
		send_req(MODE_INSERT, 32'sd42);
		send_req(MODE_LIST, '0);
		// first of two equal entries, then head, tail and a miss
		send_req(MODE_DELETE, -32'sd1);
		send_req(MODE_DELETE, 32'sh8000_0000);
		send_req(MODE_DELETE, tail_val);
		send_req(MODE_DELETE, 32'sh1357_9bdf);
		send_req(MODE_LIST, 32'sh0f0f_0f0f);

		// random: alternate filling and draining phases to sweep the occupancy
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 30 == 0) pool[4 + $urandom_range(7)] = $urandom;
			send_random((i / 30) % 2 == 0);
		end
		req_valid <= 1'b0;

		while (sb.expected_rsps.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		if (sb.expected_rsps.size() != 0) begin
			sb.errors++;
			$display("%0d responses never arrived", sb.expected_rsps.size());
		end
		$display("covered %0d requests: %0d insert, %0d delete, %0d list, %0d unused mode",
			sent, sb.mode_count[MODE_INSERT], sb.mode_count[MODE_DELETE],
			sb.mode_count[MODE_LIST], sb.mode_count[MODE_UNUSED]);
		$display("%0d responses checked, peak length %0d, full %0d, empty %0d, miss %0d, errors %0d",
			sb.checked, sb.peak, sb.status_count[STAT_FULL], sb.status_count[STAT_EMPTY],
			sb.status_count[STAT_NOT_FOUND], sb.errors);
		if (sb.errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/ola_pkg.sv
rtl/core/ola_mem.sv
rtl/core/ola_ctrl.sv
rtl/core/ordered_list_append_delete.sv
sim/testbench.sv
